[rtl/core/rmst_pkg.sv]
`default_nettype none

package rmst_pkg;

   // default tree geometry
   localparam int LEAF_BITS_DEF  = 16;
   localparam int VALUE_BITS_DEF = 31;

   // fixed port field widths
   localparam int POS_W = 16;
   localparam int VAL_W = 31;
   localparam int OUT_W = 31;

   typedef enum logic {
      OP_RAISE = 1'b0,
      OP_QUERY = 1'b1
   } opcode_type;

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_RAISE = 4'b0100,
      ST_QUERY = 4'b1000
   } state_type;

endpackage

`default_nettype wire

[rtl/core/rmst_ram.sv]
`default_nettype none

module rmst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/core/range_max_segment_tree_top.sv]
`default_nettype none

// range maximum segment tree over 2^LEAF_BITS positions
//
// request channel: a transaction is taken at a rising edge with start high and
// busy low. req_opcode selects a raise (req_position, req_new_value) or a range
// maximum query (req_range_low .. req_range_high, inclusive). unused fields are
// ignored; positions wrap to LEAF_BITS bits, values to VALUE_BITS bits.
// response channel: a query returns one transaction, rsp_max_value with
// rsp_valid high for exactly one cycle; a raise returns nothing. the receiver
// cannot stall, so the result is simply presented and dropped.
// timing: a raise keeps busy high while it visits one node per cycle on the
// leaf-to-root path, read and write overlapped, and no new transaction is
// taken until busy falls. a query walks the tree through the single read
// port, at most two node reads per level, and keeps busy high until the walk
// ends; rsp_valid rises in the cycle busy falls. an empty range reads no
// node and answers zero.
// reset: the node memory is swept to zero, one entry per cycle, all
// 2^(LEAF_BITS+1) entries (131072 at the defaults), with busy held high.

module range_max_segment_tree_top
   import rmst_pkg::*;
#(
   parameter int LEAF_BITS  = LEAF_BITS_DEF,
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output      logic             busy,
   input  wire logic             req_opcode,
   input  wire logic [POS_W-1:0] req_position,
   input  wire logic [VAL_W-1:0] req_new_value,
   input  wire logic [POS_W-1:0] req_range_low,
   input  wire logic [POS_W-1:0] req_range_high,
   output      logic             rsp_valid,
   output      logic [OUT_W-1:0] rsp_max_value
);

   localparam int NODE_W = LEAF_BITS + 1;     // heap index, node 0 unused
   localparam int QW     = LEAF_BITS + 2;     // half-open bound reaches 2^(LEAF_BITS+1)
   localparam int DEPTH  = 2 ** NODE_W;

   localparam logic [QW-1:0] LEAF_BASE = QW'(1) << LEAF_BITS;

   state_type             state_ff, state_in;
   logic [NODE_W-1:0]     clr_ff, clr_in;      // clearing sweep address
   logic [NODE_W-1:0]     node_ff, node_in;    // next node on the raise path
   logic [NODE_W-1:0]     prev_ff, prev_in;    // node whose data is coming back
   logic                  pend_ff, pend_in;    // a read is in flight
   logic [VALUE_BITS-1:0] val_ff, val_in;
   logic [QW-1:0]         lo_ff, lo_in;
   logic [QW-1:0]         hi_ff, hi_in;
   logic [VALUE_BITS-1:0] best_ff, best_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]      rsp_value_ff, rsp_value_in;

   // memory port signals
   logic                  wr_en;
   logic [NODE_W-1:0]     wr_addr;
   logic [VALUE_BITS-1:0] wr_data;
   logic                  rd_en;
   logic [NODE_W-1:0]     rd_addr;
   logic [VALUE_BITS-1:0] rd_data;

   // wrapped request fields
   logic [LEAF_BITS-1:0]  pos_w;
   logic [LEAF_BITS-1:0]  lo_w;
   logic [LEAF_BITS-1:0]  hi_w;
   logic [QW-1:0]         hi_dec;

   assign pos_w  = LEAF_BITS'(req_position);
   assign lo_w   = LEAF_BITS'(req_range_low);
   assign hi_w   = LEAF_BITS'(req_range_high);
   assign hi_dec = hi_ff - QW'(1);

   // one node store; raise writes node k while reading its parent, so the
   // two never collide, and every item ends its writes before the next read
   rmst_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (DEPTH)
   ) u_nodes (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      node_in      = node_ff;
      prev_in      = prev_ff;
      pend_in      = pend_ff;
      val_in       = val_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      best_in      = best_ff;
      rsp_valid_in = 1'b0;
      rsp_value_in = rsp_value_ff;
      wr_en        = 1'b0;
      wr_addr      = prev_ff;
      wr_data      = (rd_data < val_ff) ? val_ff : rd_data;
      rd_en        = 1'b0;
      rd_addr      = node_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            // zero one entry per cycle after reset
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + NODE_W'(1);
            if (&clr_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               node_in = {1'b1, pos_w};
               val_in  = VALUE_BITS'(req_new_value);
               pend_in = 1'b0;
               best_in = '0;
               lo_in   = LEAF_BASE + QW'(lo_w);
               hi_in   = LEAF_BASE + QW'(hi_w) + QW'(1);
               if (req_opcode == OP_QUERY) begin
                  state_in = ST_QUERY;
               end else begin
                  state_in = ST_RAISE;
               end
            end
         end
         ST_RAISE: begin
            // write back max of the node read last cycle
            if (pend_ff) begin
               wr_en = 1'b1;
            end
            if (node_ff != '0) begin
               rd_en   = 1'b1;
               rd_addr = node_ff;
               prev_in = node_ff;
               node_in = node_ff >> 1;
               pend_in = 1'b1;
            end else begin
               pend_in  = 1'b0;
               state_in = ST_IDLE;
            end
         end
         ST_QUERY: begin
            pend_in = 1'b0;
            if (pend_ff && (rd_data > best_ff)) begin
               best_in = rd_data;
            end
            if (lo_ff < hi_ff) begin
               priority if (lo_ff[0]) begin
                  // left border node, then climb unless right border is pending
                  rd_en   = 1'b1;
                  rd_addr = lo_ff[NODE_W-1:0];
                  pend_in = 1'b1;
                  if (hi_ff[0]) begin
                     lo_in = lo_ff + QW'(1);
                  end else begin
                     lo_in = (lo_ff + QW'(1)) >> 1;
                     hi_in = hi_ff >> 1;
                  end
               end else if (hi_ff[0]) begin
                  // right border node, both bounds even afterwards
                  rd_en   = 1'b1;
                  rd_addr = hi_dec[NODE_W-1:0];
                  pend_in = 1'b1;
                  lo_in   = lo_ff >> 1;
                  hi_in   = hi_dec >> 1;
               end else begin
                  lo_in = lo_ff >> 1;
                  hi_in = hi_ff >> 1;
               end
            end else if (!pend_ff) begin
               // walk finished and last read folded in
               rsp_valid_in = 1'b1;
               rsp_value_in = OUT_W'(best_ff);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      node_ff      <= node_in;
      prev_ff      <= prev_in;
      val_ff       <= val_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      best_ff      <= best_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_max_value = rsp_value_ff;

endmodule

`default_nettype wire

[rtl/core/rmst_checker.sv]
`default_nettype none

module rmst_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire logic rsp_valid
);

   // an accepted transaction occupies the block
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   // a result strobe lasts one cycle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // a result ends the work of a query
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!busy && $past(busy)))
      else $error("result outside the end of a query");

   // an idle block with no request stays quiet
   assert property (@(posedge clock) disable iff (reset)
      (!busy && !start) |=> (!busy && !rsp_valid))
      else $error("activity without a request");

endmodule

bind range_max_segment_tree_top rmst_checker u_checker (.*);

`default_nettype wire

[bench/range_max_segment_tree_checker.sv]
`timescale 1ns / 100ps

module range_max_segment_tree_checker
   import rmst_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic             busy,
   input  wire logic             req_opcode,
   input  wire logic [POS_W-1:0] req_position,
   input  wire logic [VAL_W-1:0] req_new_value,
   input  wire logic [POS_W-1:0] req_range_low,
   input  wire logic [POS_W-1:0] req_range_high,
   input  wire logic             rsp_valid,
   input  wire logic [OUT_W-1:0] rsp_max_value,
   output int                    failures,
   output int                    outstanding,
   output int                    raise_total,
   output int                    query_total,
   output int                    empty_total
);

   localparam int LEAVES = 1 << LEAF_BITS_DEF;
   localparam int NODES  = 2 * LEAVES;

   typedef struct {
      bit [POS_W-1:0] range_low;
      bit [POS_W-1:0] range_high;
      bit [OUT_W-1:0] max_value;
   } span_answer_type;

   // heap-ordered copy of the tree: node 1 is the root, leaf p is node LEAVES + p
   bit [VALUE_BITS_DEF-1:0] node_max [NODES];
   span_answer_type         answer_q [$];
   int fail_tally = 0;
   int raises     = 0;
   int queries    = 0;
   int empties    = 0;

   function automatic void raise_leaf_path(bit [POS_W-1:0] pos, bit [VAL_W-1:0] val);
      int unsigned             node;
      bit [VALUE_BITS_DEF-1:0] v;
      v    = val[VALUE_BITS_DEF-1:0];
      node = LEAVES + (pos % LEAVES);
      while (node >= 1) begin
         if (node_max[node] < v) node_max[node] = v;
         node = node >> 1;
      end
   endfunction

   function automatic bit [OUT_W-1:0] span_maximum(bit [POS_W-1:0] lo_pos,
                                                   bit [POS_W-1:0] hi_pos);
      int unsigned             lo;
      int unsigned             hi;
      bit [VALUE_BITS_DEF-1:0] best;
      best = '0;
      if ((lo_pos % LEAVES) > (hi_pos % LEAVES)) return '0;
      lo = LEAVES + (lo_pos % LEAVES);
      hi = LEAVES + (hi_pos % LEAVES) + 1;
      // bottom-up walk over the half-open span
      while (lo < hi) begin
         if (lo % 2 == 1) begin
            if (node_max[lo] > best) best = node_max[lo];
            lo++;
         end
         if (hi % 2 == 1) begin
            hi--;
            if (node_max[hi] > best) best = node_max[hi];
         end
         lo = lo >> 1;
         hi = hi >> 1;
      end
      return OUT_W'(best);
   endfunction

   always @(posedge clock) begin : watch
      span_answer_type head;
      bit [OUT_W-1:0]  answer;
      if (reset) begin
         foreach (node_max[k]) node_max[k] = '0;
         answer_q.delete();
         fail_tally = 0;
         raises     = 0;
         queries    = 0;
         empties    = 0;
      end else begin
         if (rsp_valid === 1'b1) begin
            if (answer_q.size() == 0) begin
               fail_tally++;
               if (fail_tally <= 10)
                  $display("%0t: max_value %0h arrived with no query waiting",
                           $time, rsp_max_value);
            end else begin
               head = answer_q.pop_front();
               if (rsp_max_value !== head.max_value) begin
                  fail_tally++;
                  if (fail_tally <= 10)
                     $display("%0t: query [%0h..%0h] max_value expected %0h got %0h",
                              $time, head.range_low, head.range_high,
                              head.max_value, rsp_max_value);
               end
            end
         end
         if (start === 1'b1 && busy === 1'b0) begin
            if (opcode_type'(req_opcode) == OP_QUERY) begin
               queries++;
               if (req_range_low > req_range_high) empties++;
               answer = span_maximum(req_range_low, req_range_high);
               answer_q.push_back('{req_range_low, req_range_high, answer});
            end else begin
               raises++;
               raise_leaf_path(req_position, req_new_value);
            end
         end
      end
      failures    <= fail_tally;
      outstanding <= answer_q.size();
      raise_total <= raises;
      query_total <= queries;
      empty_total <= empties;
   end

endmodule

[bench/tb_range_max_segment_tree_top.sv]
`timescale 1ns / 100ps

module tb_range_max_segment_tree_top;
   import rmst_pkg::*;

   logic             clock = 1'b0;
   logic             reset;
   logic             start;
   logic             busy;
   logic             req_opcode;
   logic [POS_W-1:0] req_position;
   logic [VAL_W-1:0] req_new_value;
   logic [POS_W-1:0] req_range_low;
   logic [POS_W-1:0] req_range_high;
   logic             rsp_valid;
   logic [OUT_W-1:0] rsp_max_value;

   int failures;
   int outstanding;
   int raise_total;
   int query_total;
   int empty_total;

   // raises and most queries cluster in a 512-position window so that
   // query answers come from real data rather than from untouched leaves
   bit [POS_W-1:0] hot_base;

   always #5 clock = ~clock;

   range_max_segment_tree_top dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_opcode     (req_opcode),
      .req_position   (req_position),
      .req_new_value  (req_new_value),
      .req_range_low  (req_range_low),
      .req_range_high (req_range_high),
      .rsp_valid      (rsp_valid),
      .rsp_max_value  (rsp_max_value)
   );

   range_max_segment_tree_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_opcode     (req_opcode),
      .req_position   (req_position),
      .req_new_value  (req_new_value),
      .req_range_low  (req_range_low),
      .req_range_high (req_range_high),
      .rsp_valid      (rsp_valid),
      .rsp_max_value  (rsp_max_value),
      .failures       (failures),
      .outstanding    (outstanding),
      .raise_total    (raise_total),
      .query_total    (query_total),
      .empty_total    (empty_total)
   );

   // present one transaction and hold it until the block takes it
   // (start high at an edge where busy is low); returns at that edge
   task automatic issue(input opcode_type op, input bit [POS_W-1:0] pos,
                        input bit [VAL_W-1:0] val, input bit [POS_W-1:0] lo,
                        input bit [POS_W-1:0] hi);
      start          <= 1'b1;
      req_opcode     <= op;
      req_position   <= pos;
      req_new_value  <= val;
      req_range_low  <= lo;
      req_range_high <= hi;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   // sender gap; the request fields carry junk while start is low
   task automatic rest(input int cycles);
      start          <= 1'b0;
      req_opcode     <= 1'($urandom);
      req_position   <= POS_W'($urandom);
      req_new_value  <= VAL_W'($urandom);
      req_range_low  <= POS_W'($urandom);
      req_range_high <= POS_W'($urandom);
      repeat (cycles) @(posedge clock);
   endtask

   task automatic random_item();
      bit [POS_W-1:0] a;
      bit [POS_W-1:0] b;
      bit [POS_W-1:0] tmp;
      bit [VAL_W-1:0] val;
      int             pick;
      pick = $urandom_range(0, 99);
      // spread values over magnitudes so maxima keep moving
      case ($urandom_range(0, 3))
         0: val = VAL_W'($urandom);
         1: val = VAL_W'($urandom_range(0, 255));
         2: val = VAL_W'($urandom_range(0, 65535));
         default: val = VAL_W'($urandom) >> $urandom_range(0, 30);
      endcase
      a = POS_W'($urandom);
      b = POS_W'($urandom);
      if (pick < 50) begin
         // raise, mostly inside the window; range fields are junk
         tmp = (pick < 35) ? hot_base + POS_W'($urandom_range(0, 511)) : POS_W'($urandom);
         issue(OP_RAISE, tmp, val, a, b);
      end else if (pick < 78) begin
         // ordered range inside the window
         a = hot_base + POS_W'($urandom_range(0, 511));
         b = hot_base + POS_W'($urandom_range(0, 511));
         if (a > b) begin
            tmp = a;
            a   = b;
            b   = tmp;
         end
         issue(OP_QUERY, POS_W'($urandom), val, a, b);
      end else if (pick < 86) begin
         // fully random bounds, empty about half the time
         issue(OP_QUERY, POS_W'($urandom), val, a, b);
      end else if (pick < 91) begin
         // single leaf in the window
         a = hot_base + POS_W'($urandom_range(0, 511));
         issue(OP_QUERY, POS_W'($urandom), val, a, a);
      end else if (pick < 95) begin
         // empty range: low strictly above high
         if (a == b) begin
            a = (a == '0) ? POS_W'(1) : a;
            b = a - 1'b1;
         end else if (a < b) begin
            tmp = a;
            a   = b;
            b   = tmp;
         end
         issue(OP_QUERY, POS_W'($urandom), val, a, b);
      end else begin
         // range anchored at either end of the tree
         if ($urandom_range(0, 1) == 0)
            issue(OP_QUERY, POS_W'($urandom), val, '0, a);
         else
            issue(OP_QUERY, POS_W'($urandom), val, a, '1);
      end
   endtask

   initial begin
      reset          <= 1'b1;
      start          <= 1'b0;
      req_opcode     <= OP_RAISE;
      req_position   <= '0;
      req_new_value  <= '0;
      req_range_low  <= '0;
      req_range_high <= '0;
      hot_base = POS_W'($urandom_range(0, 65023));
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed part; the block is still sweeping its memory, so the first
      // transaction simply waits for busy to drop

      // nothing written yet: whole tree answers zero
      issue(OP_QUERY, '0, '0, '0, '1);
      // both end leaves, a zero value and a small one
      issue(OP_RAISE, '0, VAL_W'(5), '1, '0);
      issue(OP_RAISE, '1, '1, '0, '1);
      issue(OP_RAISE, POS_W'(16'h8000), '0, '0, '0);
      issue(OP_RAISE, POS_W'(1), VAL_W'(1), '0, '0);
      // a smaller value must not lower leaf 0
      issue(OP_RAISE, '0, VAL_W'(3), '0, '0);
      issue(OP_QUERY, '1, '1, '0, '0);
      issue(OP_QUERY, '0, '0, '1, '1);
      issue(OP_QUERY, '0, '0, POS_W'(1), POS_W'(16'hfffe));
      issue(OP_QUERY, '0, '0, '0, '1);
      // span whose only written leaf holds zero
      issue(OP_QUERY, '0, '0, POS_W'(2), POS_W'(16'h8000));
      // empty ranges
      issue(OP_QUERY, '0, '0, POS_W'(5), POS_W'(4));
      issue(OP_QUERY, '0, '0, '1, '0);
      // unwritten span
      issue(OP_QUERY, '0, '0, POS_W'(100), POS_W'(200));
      // alternating bit patterns on positions, values and query bounds
      issue(OP_RAISE, POS_W'(16'h5555), VAL_W'(31'h2aaaaaaa), '1, '0);
      issue(OP_RAISE, POS_W'(16'haaaa), VAL_W'(31'h55555555), '0, '1);
      issue(OP_QUERY, '1, '1, POS_W'(16'h5555), POS_W'(16'haaaa));
      issue(OP_QUERY, '0, '0, POS_W'(16'h5556), POS_W'(16'haaa9));
      issue(OP_QUERY, '0, '0, POS_W'(16'h5555), POS_W'(16'h5555));
      // raise by one and look again
      issue(OP_RAISE, POS_W'(16'h5555), VAL_W'(31'h2aaaaaab), '0, '0);
      issue(OP_QUERY, '0, '0, POS_W'(16'h5555), POS_W'(16'h5555));

      // random part
      for (int i = 0; i < 450; i++) begin
         random_item();
         if (i == 225) begin
            // drain: hold off until every query answer is in
            rest(1);
            while (outstanding != 0) @(posedge clock);
         end else if (i == 300) begin
            // move the hot window to fresh ground
            hot_base = POS_W'($urandom_range(0, 65023));
            rest($urandom_range(1, 19));
         end else if (i < 380 && !(i >= 150 && i < 200) && $urandom_range(0, 3) == 0) begin
            // random bursts of sender idling; back to back around the
            // middle and through the final stretch
            rest($urandom_range(1, 19));
         end
      end

      // let the last answers arrive, then watch for any stray result
      rest(1);
      for (int g = 0; g < 500 && outstanding != 0; g++) @(posedge clock);
      repeat (40) @(posedge clock);

      if (outstanding != 0)
         $display("%0d query answers never arrived", outstanding);
      $display("covered %0d raises and %0d range queries, %0d of them empty ranges",
               raise_total, query_total, empty_total);
      $display("with sender gaps, a mid-run drain, a window move and a back-to-back tail");
      if (failures == 0 && outstanding == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // watchdog: memory sweep plus every transaction at its slowest, several times over
   initial begin
      #8_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

[sim.f]
rtl/core/rmst_pkg.sv
rtl/core/rmst_ram.sv
rtl/core/range_max_segment_tree_top.sv
rtl/core/rmst_checker.sv
bench/range_max_segment_tree_checker.sv
bench/tb_range_max_segment_tree_top.sv
